FILE: rtl/tbpe_pkg.sv
// Shared types and constants for the tape block payload extractor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tbpe_pkg;

  // Width of one tape byte and of one payload byte.
  localparam int unsigned DATA_W = 8;

  // Total image size; the byte that reaches it is marked last.
  localparam int unsigned IMAGE_BYTES = 16384;
  localparam int unsigned EMIT_W = $clog2(IMAGE_BYTES + 1);

  // Header bytes dropped from blocks while nothing has been emitted yet.
  localparam int unsigned HEADER_SKIP = 5;
  localparam int unsigned SKIP_W = 3;

  // Sync pattern FF 01 3C 01.
  localparam int unsigned SYNC_LEN = 4;
  localparam int unsigned SYNC_W = $clog2(SYNC_LEN);

  typedef logic [DATA_W-1:0] byte_t;

  localparam byte_t SYNC_PATTERN [SYNC_LEN] = '{8'hFF, 8'h01, 8'h3C, 8'h01};

  // One result beat as it leaves the parser.
  typedef struct packed {
    logic  valid;
    byte_t data;
    logic  last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/tbpe_in_stage.sv
// Input register of the tape block payload extractor.
// Holds one accepted tape byte until the parser takes it; uses tbpe_pkg.
`default_nettype none

module tbpe_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire tbpe_pkg::byte_t tape_byte_i,
  input  wire logic            advance_i,
  output logic                 step_o,
  output tbpe_pkg::byte_t      byte_o
);

  logic            valid_q, valid_d;
  tbpe_pkg::byte_t byte_q, byte_d;
  logic            load;

  // The register takes a new beat whenever it is empty or its beat moves on.
  assign load       = advance_i || !valid_q;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;
  assign byte_d     = load ? tape_byte_i : byte_q;

  assign step_o = valid_q && advance_i;
  assign byte_o = byte_q;

  // Valid flag is reset; the data byte needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

`default_nettype wire

FILE: rtl/tbpe_parser.sv
// Sync hunt, header skip and payload copy for one tape byte per step.
// Keeps the block state and forms the result beat; uses tbpe_pkg.
`default_nettype none

module tbpe_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire tbpe_pkg::byte_t byte_i,
  output tbpe_pkg::result_t    result_o
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_SKIP   = 3'd2,
    PH_COPY   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  phase_e                              phase_q, phase_d;
  logic [tbpe_pkg::SYNC_W-1:0]         sync_step_q, sync_step_d;
  tbpe_pkg::byte_t                     bytes_left_q, bytes_left_d;
  logic [tbpe_pkg::SKIP_W-1:0]         skip_left_q, skip_left_d;
  logic [tbpe_pkg::EMIT_W-1:0]         emitted_q, emitted_d;
  tbpe_pkg::byte_t                     len_left;
  logic [tbpe_pkg::SKIP_W-1:0]         len_skip;
  logic [tbpe_pkg::SKIP_W-1:0]         skip_dec;
  tbpe_pkg::byte_t                     left_dec;
  logic [tbpe_pkg::EMIT_W-1:0]         emit_inc;

  // Block length seen at the length byte, with the header taken off if needed.
  always_comb begin
    if (emitted_q == '0) begin
      len_skip = tbpe_pkg::SKIP_W'(tbpe_pkg::HEADER_SKIP);
      if (byte_i > tbpe_pkg::DATA_W'(tbpe_pkg::HEADER_SKIP)) begin
        len_left = byte_i - tbpe_pkg::DATA_W'(tbpe_pkg::HEADER_SKIP);
      end else begin
        len_left = '0;
      end
    end else begin
      len_skip = '0;
      len_left = byte_i;
    end
  end

  assign skip_dec = skip_left_q - tbpe_pkg::SKIP_W'(1);
  assign left_dec = bytes_left_q - tbpe_pkg::DATA_W'(1);
  assign emit_inc = emitted_q + tbpe_pkg::EMIT_W'(1);

  // Next state and result for the byte in hand.
  always_comb begin
    phase_d      = phase_q;
    sync_step_d  = sync_step_q;
    bytes_left_d = bytes_left_q;
    skip_left_d  = skip_left_q;
    emitted_d    = emitted_q;
    result_o     = '{valid: 1'b0, data: byte_i, last: 1'b0};
    unique case (phase_q)
      PH_LENGTH: begin
        bytes_left_d = len_left;
        skip_left_d  = len_skip;
        if (len_skip != '0) begin
          phase_d = PH_SKIP;
        end else if (len_left != '0) begin
          phase_d = PH_COPY;
        end else begin
          phase_d     = PH_HUNT;
          sync_step_d = '0;
        end
      end
      PH_SKIP: begin
        skip_left_d = skip_dec;
        if (skip_dec == '0) begin
          if (bytes_left_q != '0) begin
            phase_d = PH_COPY;
          end else begin
            phase_d     = PH_HUNT;
            sync_step_d = '0;
          end
        end
      end
      PH_COPY: begin
        emitted_d       = emit_inc;
        bytes_left_d    = left_dec;
        result_o.valid  = 1'b1;
        if (emit_inc >= tbpe_pkg::EMIT_W'(tbpe_pkg::IMAGE_BYTES)) begin
          result_o.last = 1'b1;
          phase_d       = PH_DONE;
        end else if (left_dec == '0) begin
          phase_d     = PH_HUNT;
          sync_step_d = '0;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        // Hunting; a mismatching FF counts as the first pattern byte.
        phase_d = PH_HUNT;
        if (byte_i == tbpe_pkg::SYNC_PATTERN[sync_step_q]) begin
          if (sync_step_q == tbpe_pkg::SYNC_W'(tbpe_pkg::SYNC_LEN - 1)) begin
            sync_step_d = '0;
            phase_d     = PH_LENGTH;
          end else begin
            sync_step_d = sync_step_q + tbpe_pkg::SYNC_W'(1);
          end
        end else if (byte_i == tbpe_pkg::SYNC_PATTERN[0]) begin
          sync_step_d = tbpe_pkg::SYNC_W'(1);
        end else begin
          sync_step_d = '0;
        end
      end
    endcase
    if (!step_i) begin
      result_o.valid = 1'b0;
    end
  end

  // State moves only when a byte is stepped through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      sync_step_q  <= '0;
      bytes_left_q <= '0;
      skip_left_q  <= '0;
      emitted_q    <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      sync_step_q  <= sync_step_d;
      bytes_left_q <= bytes_left_d;
      skip_left_q  <= skip_left_d;
      emitted_q    <= emitted_d;
    end
  end

  // The image-complete byte always leads into the done phase.
  a_last_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.last) |=> (phase_q == PH_DONE))
    else $error("last byte did not end the image");

  // Once done, the block stays done until reset.
  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |=> (phase_q == PH_DONE))
    else $error("left the done phase");

  // The emitted count never passes the image size.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= tbpe_pkg::EMIT_W'(tbpe_pkg::IMAGE_BYTES))
    else $error("emitted count beyond image size");

  // Copying never starts with nothing left in the block.
  a_copy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COPY) |-> (bytes_left_q != '0))
    else $error("copy phase with empty block");

endmodule

`default_nettype wire

FILE: rtl/tbpe_out_stage.sv
// Output register of the tape block payload extractor.
// Holds one result beat until the receiver takes it; uses tbpe_pkg.
`default_nettype none

module tbpe_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tbpe_pkg::result_t result_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tbpe_pkg::byte_t        data_byte_o,
  output logic                   image_last_o
);

  logic            valid_q, valid_d;
  tbpe_pkg::byte_t data_q, data_d;
  logic            last_q, last_d;

  // Free when empty or when its beat is taken this cycle.
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? result_i.valid : valid_q;
  assign data_d  = ready_o ? result_i.data  : data_q;
  assign last_d  = ready_o ? result_i.last  : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign data_byte_o  = data_q;
  assign image_last_o = last_q;

endmodule

`default_nettype wire

FILE: rtl/tape_block_payload_extractor.sv
// Tape block payload extractor: scans a tape byte stream for
// FF 01 3C 01 sync marks and passes out the payload bytes of each block.
//
// Input channel: tape_byte_i with in_valid_i / in_stall_o. A beat is taken
// at a rising edge with valid high and stall low. Output channel:
// data_byte_o and image_last_o with out_valid_o / out_stall_i, the same rule.
// Only payload bytes produce output beats; sync, length and header bytes
// are consumed silently. The first blocks drop a five-byte header while
// nothing has been emitted yet. The 16384th output byte carries image_last_o
// and everything after it is discarded until reset.
//
// An input beat passes the input register, then the parser step into the
// output register. Throughput: one byte per cycle while the receiver does not
// stall, set by the combinational parser step between the two registers.
// When the receiver stalls with a beat waiting, the output register and the
// parser hold. in_stall_o rises in that same cycle if the input register
// holds a byte, or else after one more beat has filled it.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to sync hunting with the emitted count at zero.
`default_nettype none

module tape_block_payload_extractor (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [tbpe_pkg::DATA_W-1:0] tape_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [tbpe_pkg::DATA_W-1:0]     data_byte_o,
  output logic                            image_last_o
);

  logic              advance;
  logic              step;
  tbpe_pkg::byte_t   step_byte;
  tbpe_pkg::result_t result;

  // Input register.
  tbpe_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .tape_byte_i (tape_byte_i),
    .advance_i   (advance),
    .step_o      (step),
    .byte_o      (step_byte)
  );

  // Per-byte parser.
  tbpe_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (step_byte),
    .result_o (result)
  );

  // Output register.
  tbpe_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .result_i     (result),
    .ready_o      (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .image_last_o (image_last_o)
  );

endmodule

`default_nettype wire
